@@ sv/swlc_pkg.sv @@
package swlc_pkg;

    // window geometry
    localparam int WinBits = 32;
    localparam int PopW    = $clog2(WinBits + 1);

    // field widths
    localparam int OpW   = 2;
    localparam int IdW   = 32;
    localparam int CntW  = 32;
    localparam int IntvW = 16;

    localparam logic [IntvW-1:0] DecayIntvReset = 16'd32;

    // opcodes of the input transaction
    localparam logic [OpW-1:0] OpPacket    = 2'd0;
    localparam logic [OpW-1:0] OpDecay     = 2'd1;
    localparam logic [OpW-1:0] OpFullReset = 2'd2;
    localparam logic [OpW-1:0] OpWinReset  = 2'd3;

    // command queue between front and back
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        CMD_PACKET,
        CMD_DECAY,
        CMD_FULL_RESET,
        CMD_WIN_RESET
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [IdW-1:0]     seq_id;
        logic               id_small;   // id below the window size
    } cmd_t;

    function automatic logic [PopW-1:0] popcount(input logic [WinBits-1:0] v);
        logic [PopW-1:0] n;
        n = '0;
        for (int i = 0; i < WinBits; i++)
        begin
            n = n + PopW'(v[i]);
        end
        return n;
    endfunction

endpackage

@@ sv/swlc_if.sv @@
interface swlc_pkt_if;
    logic                     valid;
    logic                     ready;
    logic [swlc_pkg::OpW-1:0] opcode;
    logic [swlc_pkg::IdW-1:0] seq_id;

    modport source (output valid, output opcode, output seq_id, input ready);
    modport sink   (input valid, input opcode, input seq_id, output ready);
endinterface

interface swlc_stats_if;
    logic                      valid;
    logic                      ready;
    logic [swlc_pkg::CntW-1:0] received_recent;
    logic [swlc_pkg::CntW-1:0] lost_recent;
    logic [swlc_pkg::CntW-1:0] received_total;
    logic [swlc_pkg::CntW-1:0] lost_total;
    logic [swlc_pkg::IdW-1:0]  newest_id;

    modport source (output valid, output received_recent, output lost_recent,
                    output received_total, output lost_total, output newest_id,
                    input ready);
    modport sink   (input valid, input received_recent, input lost_recent,
                    input received_total, input lost_total, input newest_id,
                    output ready);
endinterface

interface swlc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [swlc_pkg::IntvW-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/swlc_front.sv @@
module swlc_front (
    swlc_pkt_if.sink        pkt,
    output logic            push_valid,
    output swlc_pkg::cmd_t  push_cmd,
    input  logic            push_ready
);
    import swlc_pkg::*;

    assign pkt.ready  = push_ready;
    assign push_valid = pkt.valid;

    always_comb
    begin
        push_cmd.seq_id   = pkt.seq_id;
        push_cmd.id_small = (pkt.seq_id < IdW'(WinBits));
        case (pkt.opcode)
            OpPacket:    push_cmd.kind = CMD_PACKET;
            OpDecay:     push_cmd.kind = CMD_DECAY;
            OpFullReset: push_cmd.kind = CMD_FULL_RESET;
            OpWinReset:  push_cmd.kind = CMD_WIN_RESET;
            default:     push_cmd.kind = CMD_PACKET;
        endcase
    end

endmodule

@@ sv/swlc_queue.sv @@
module swlc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  swlc_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    output logic            pop_valid,
    output swlc_pkg::cmd_t  pop_cmd,
    input  logic            pop_ready
);
    import swlc_pkg::*;

    cmd_t              entry_reg [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != QCntW'(QDepth));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCntW'(QDepth))
        else $error("command queue over depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue count lost a push");

    a_full_blocks_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCntW'(QDepth)) |-> !push)
        else $error("push accepted into a full command queue");

endmodule

@@ sv/swlc_back.sv @@
module swlc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  swlc_pkg::cmd_t  cmd,
    output logic            cmd_ready,
    swlc_cfg_if.sink        cfg,
    swlc_stats_if.source    stats
);
    import swlc_pkg::*;

    logic [IntvW-1:0]   decay_intv_reg;
    logic [WinBits-1:0] win_reg, win_next;
    logic [IdW-1:0]     newest_reg, newest_next;
    logic [IdW-1:0]     last_decay_reg, last_decay_next;
    logic [CntW-1:0]    rx_recent_reg, rx_recent_next;
    logic [CntW-1:0]    lost_recent_reg, lost_recent_next;
    logic [CntW-1:0]    rx_total_reg, rx_total_next;
    logic [CntW-1:0]    lost_total_reg, lost_total_next;
    logic               out_valid_reg, out_valid_next;

    logic               pop;
    logic               newer;
    logic [IdW-1:0]     age_new, age_old, passed;
    logic [WinBits-1:0] leaving;
    logic [PopW-1:0]    rx_near, rx_all;
    logic [CntW-1:0]    add_rx, add_lost;

    assign cfg.ready   = 1'b1;
    assign cmd_ready   = !out_valid_reg || stats.ready;
    assign pop         = cmd_valid && cmd_ready;
    assign stats.valid = out_valid_reg;

    assign newer   = (cmd.seq_id > newest_reg);
    assign age_new = cmd.seq_id - newest_reg;
    assign age_old = newest_reg - cmd.seq_id;
    assign passed  = newest_reg - last_decay_reg;
    assign leaving = win_reg >> (IdW'(WinBits) - age_new);
    assign rx_near = popcount(leaving);
    assign rx_all  = popcount(win_reg);

    always_comb
    begin
        win_next         = win_reg;
        newest_next      = newest_reg;
        last_decay_next  = last_decay_reg;
        rx_recent_next   = rx_recent_reg;
        lost_recent_next = lost_recent_reg;
        rx_total_next    = rx_total_reg;
        lost_total_next  = lost_total_reg;
        add_rx           = '0;
        add_lost         = '0;
        case (cmd.kind)
            CMD_PACKET:
            begin
                if (newer)
                begin
                    if (age_new < IdW'(WinBits))
                    begin
                        add_rx   = CntW'(rx_near);
                        add_lost = age_new - CntW'(rx_near);
                        win_next = win_reg << age_new;
                    end
                    else
                    begin
                        add_rx = CntW'(rx_all);
                        if (age_new >= IdW'(2 * WinBits))
                        begin
                            // beyond the flushed window the gap is all loss
                            add_lost = age_new - CntW'(WinBits) - CntW'(rx_all);
                            win_next = '0;
                        end
                        else
                        begin
                            add_lost = CntW'(WinBits) - CntW'(rx_all);
                            win_next = WinBits'(1) << (age_new - IdW'(WinBits));
                        end
                    end
                    win_next[0]      = 1'b1;
                    newest_next      = cmd.seq_id;
                    rx_recent_next   = rx_recent_reg + add_rx;
                    rx_total_next    = rx_total_reg + add_rx;
                    lost_recent_next = lost_recent_reg + add_lost;
                    lost_total_next  = lost_total_reg + add_lost;
                    if (cmd.id_small)
                    begin
                        rx_recent_next   = '0;
                        lost_recent_next = '0;
                        rx_total_next    = '0;
                        lost_total_next  = '0;
                    end
                end
                else if (age_old < IdW'(WinBits))
                begin
                    win_next = win_reg | (WinBits'(1) << age_old);
                end
            end
            CMD_DECAY:
            begin
                if (passed >= IdW'(decay_intv_reg))
                begin
                    rx_recent_next   = rx_recent_reg >> 1;
                    lost_recent_next = lost_recent_reg >> 1;
                    last_decay_next  = newest_reg;
                end
            end
            CMD_FULL_RESET:
            begin
                rx_recent_next   = '0;
                lost_recent_next = '0;
                rx_total_next    = '0;
                lost_total_next  = '0;
                win_next         = '0;
                newest_next      = '0;
                last_decay_next  = '0;
            end
            CMD_WIN_RESET:
            begin
                win_next        = '0;
                newest_next     = '0;
                last_decay_next = '0;
            end
            default:
            begin
                win_next = win_reg;
            end
        endcase
    end

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (stats.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_intv_reg  <= DecayIntvReset;
            win_reg         <= '0;
            newest_reg      <= '0;
            last_decay_reg  <= '0;
            rx_recent_reg   <= '0;
            lost_recent_reg <= '0;
            rx_total_reg    <= '0;
            lost_total_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                decay_intv_reg <= cfg.data;
            end
            if (pop)
            begin
                win_reg         <= win_next;
                newest_reg      <= newest_next;
                last_decay_reg  <= last_decay_next;
                rx_recent_reg   <= rx_recent_next;
                lost_recent_reg <= lost_recent_next;
                rx_total_reg    <= rx_total_next;
                lost_total_reg  <= lost_total_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded with the state after each command
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            stats.received_recent <= rx_recent_next;
            stats.lost_recent     <= lost_recent_next;
            stats.received_total  <= rx_total_next;
            stats.lost_total      <= lost_total_next;
            stats.newest_id       <= newest_next;
        end
    end

    a_full_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.kind == CMD_FULL_RESET) |=>
            (rx_total_reg == '0 && lost_total_reg == '0 && newest_reg == '0))
        else $error("full reset left state behind");

    a_newer_marks_bit0: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.kind == CMD_PACKET && newer) |=>
            (win_reg[0] && newest_reg == $past(cmd.seq_id)))
        else $error("newer packet not recorded as newest");

    a_newest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.kind == CMD_PACKET) |=> newest_reg >= $past(newest_reg))
        else $error("newest id went backwards on a packet");

    a_result_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !pop) |=> !out_valid_reg)
        else $error("result shown without a command");

endmodule

@@ sv/sliding_window_loss_counter.sv @@
// sliding window packet loss counter
// path: an accepted input transaction is written into the command queue register,
//   then the back end applies it and loads the output register with the result
// throughput: one transaction per cycle while the stats receiver keeps up; the
//   window shift, popcount and counter update in the back end are combinational
// reset: asynchronous active low; state clears at once, decay_interval returns to 32
module sliding_window_loss_counter (
    input  logic          clk,
    input  logic          rst_n,
    swlc_pkt_if.sink      pkt,
    swlc_cfg_if.sink      cfg,
    swlc_stats_if.source  stats
);
    import swlc_pkg::*;

    // front to queue
    logic  push_valid;
    logic  push_ready;
    cmd_t  push_cmd;

    // queue to back
    logic  cmd_valid;
    logic  cmd_ready;
    cmd_t  cmd;

    // front: takes each packet transaction and decodes the opcode into a command,
    // flagging ids that sit below the window size
    swlc_front u_front (
        .pkt        (pkt),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // two-entry command queue so the front keeps accepting while the back stalls, until it is full
    swlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (cmd_valid),
        .pop_cmd    (cmd),
        .pop_ready  (cmd_ready)
    );

    // back: owns the bitmap, offsets, counters and decay interval, applies one
    // command per cycle unless a stalled result blocks it, parks the snapshot
    // in the output register, takes the next command in the cycle the result leaves
    swlc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .cfg       (cfg),
        .stats     (stats)
    );

endmodule

@@ test/swlc_scoreboard_pkg.sv @@
package swlc_scoreboard_pkg;

    import swlc_pkg::*;

    typedef struct packed {
        logic [CntW-1:0] received_recent;
        logic [CntW-1:0] lost_recent;
        logic [CntW-1:0] received_total;
        logic [CntW-1:0] lost_total;
        logic [IdW-1:0]  newest_id;
    } loss_stats_t;

    localparam int StatFields = 5;
    localparam int ReportLimit = 10;

    class loss_count_scoreboard;

        // mirrored block state
        logic [WinBits-1:0] seen_bits;
        logic [IdW-1:0]     newest;
        logic [IdW-1:0]     last_decay;
        logic [CntW-1:0]    rx_recent;
        logic [CntW-1:0]    lost_recent;
        logic [CntW-1:0]    rx_total;
        logic [CntW-1:0]    lost_total;
        logic [IntvW-1:0]   interval;

        loss_stats_t stats_due[$];

        int inputs_noted;
        int results_checked;
        int decays_applied;
        int failures;
        int mismatches;

        function new();
            interval = DecayIntvReset;
            clear_window();
            clear_counters();
            inputs_noted = 0;
            results_checked = 0;
            decays_applied = 0;
            failures = 0;
            mismatches = 0;
        endfunction

        function void clear_window();
            seen_bits = '0;
            newest = '0;
            last_decay = '0;
        endfunction

        function void clear_counters();
            rx_recent = '0;
            lost_recent = '0;
            rx_total = '0;
            lost_total = '0;
        endfunction

        function void add_counts(logic [CntW-1:0] rx, logic [CntW-1:0] lost);
            rx_recent += rx;
            rx_total += rx;
            lost_recent += lost;
            lost_total += lost;
        endfunction

        function void set_interval(logic [IntvW-1:0] value);
            interval = value;
        endfunction

        function void apply_packet(logic [IdW-1:0] id);
            logic [IdW-1:0]     age;
            logic [CntW-1:0]    rx;
            logic [WinBits-1:0] leaving;
            if (id > newest)
            begin
                age = id - newest;
                if (age < 32'(WinBits))
                begin
                    // bits pushed out of the top of the window
                    leaving = seen_bits >> (32'(WinBits) - age);
                    rx = 32'($countones(leaving));
                    add_counts(rx, age - rx);
                    seen_bits = seen_bits << age;
                end
                else
                begin
                    rx = 32'($countones(seen_bits));
                    add_counts(rx, 32'(WinBits) - rx);
                    seen_bits = '0;
                    if (age >= 32'(2 * WinBits))
                        add_counts('0, age - 32'(2 * WinBits));
                    else
                        seen_bits[age - 32'(WinBits)] = 1'b1;
                end
                seen_bits[0] = 1'b1;
                newest = id;
                if (id < 32'(WinBits))
                    clear_counters();
            end
            else
            begin
                age = newest - id;
                if (age < 32'(WinBits))
                    seen_bits[age] = 1'b1;
            end
        endfunction

        function void apply_decay();
            logic [IdW-1:0] passed;
            passed = newest - last_decay;
            if (passed >= {16'd0, interval})
            begin
                rx_recent = rx_recent >> 1;
                lost_recent = lost_recent >> 1;
                last_decay = newest;
                decays_applied++;
            end
        endfunction

        function void note_input(logic [OpW-1:0] op, logic [IdW-1:0] id);
            loss_stats_t due;
            case (op)
                OpPacket:    apply_packet(id);
                OpDecay:     apply_decay();
                OpFullReset:
                begin
                    clear_counters();
                    clear_window();
                end
                default:     clear_window();
            endcase
            due.received_recent = rx_recent;
            due.lost_recent = lost_recent;
            due.received_total = rx_total;
            due.lost_total = lost_total;
            due.newest_id = newest;
            stats_due.push_back(due);
            inputs_noted++;
        endfunction

        function void check_stats(loss_stats_t got);
            loss_stats_t due;
            string       names[StatFields];
            logic [31:0] want_f;
            logic [31:0] got_f;
            bit          bad;
            names = '{"received_recent", "lost_recent", "received_total",
                      "lost_total", "newest_id"};
            if (stats_due.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= ReportLimit)
                    $display("unexpected stats transaction, newest_id %h", got.newest_id);
                return;
            end
            due = stats_due.pop_front();
            results_checked++;
            bad = 1'b0;
            for (int f = 0; f < StatFields; f++)
            begin
                want_f = due[(StatFields - 1 - f) * 32 +: 32];
                got_f = got[(StatFields - 1 - f) * 32 +: 32];
                if (want_f !== got_f)
                begin
                    bad = 1'b1;
                    mismatches++;
                    if (mismatches <= ReportLimit)
                        $display("result %0d: %s expected %h, got %h",
                                 results_checked, names[f], want_f, got_f);
                end
            end
            if (bad)
                failures++;
        endfunction

        function int pending_count();
            return stats_due.size();
        endfunction

    endclass

endpackage

@@ test/sliding_window_loss_counter_test.sv @@
module sliding_window_loss_counter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import swlc_pkg::*;
    import swlc_scoreboard_pkg::*;

    // generous bound for the watchdog
    localparam int CycleLimit = 200000;
    localparam int PhaseItems = 190;

    logic clk;
    logic rst_n;

    swlc_pkt_if   pkt ();
    swlc_cfg_if   cfg ();
    swlc_stats_if stats ();

    sliding_window_loss_counter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt),
        .cfg   (cfg),
        .stats (stats)
    );

    loss_count_scoreboard sb;

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    int interval_writes;

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // cycle counter doubles as the watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_count());
            $display("FAIL sliding_window_loss_counter");
            $finish;
        end
    end

    // receiver back-pressure, decided afresh at every falling edge
    always @(negedge clk)
    begin
        stats.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every stats transaction is compared against the oldest prediction
    always @(posedge clk)
    begin
        loss_stats_t got;
        if (rst_n && stats.valid && stats.ready)
        begin
            got.received_recent = stats.received_recent;
            got.lost_recent = stats.lost_recent;
            got.received_total = stats.received_total;
            got.lost_total = stats.lost_total;
            got.newest_id = stats.newest_id;
            sb.check_stats(got);
        end
    end

    // one packet-channel transaction; called and returning at a falling edge,
    // valid is left high so back-to-back transactions need no gap
    task automatic send_pkt(input logic [OpW-1:0] op, input logic [IdW-1:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pkt.valid <= 1'b0;
            @(negedge clk);
        end
        pkt.valid <= 1'b1;
        pkt.opcode <= op;
        pkt.seq_id <= id;
        do
            @(posedge clk);
        while (!pkt.ready);
        sb.note_input(op, id);
        @(negedge clk);
    endtask

    task automatic end_burst();
        pkt.valid <= 1'b0;
    endtask

    // wait for the block to drain; every transaction yields a result
    task automatic wait_drained();
        while (sb.pending_count() != 0)
            @(negedge clk);
    endtask

    // decay interval write, only issued while the block is idle
    task automatic write_interval(input logic [IntvW-1:0] value);
        cfg.valid <= 1'b1;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.set_interval(value);
        interval_writes++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // hand-picked corner cases, run at the reset interval of 32
    task automatic run_directed();
        send_pkt(OpPacket, 32'd0);             // equal to newest, sets bit 0 only
        send_pkt(OpPacket, 32'd1);
        send_pkt(OpPacket, 32'd5);             // small forward step
        send_pkt(OpPacket, 32'd3);             // late arrival inside the window
        send_pkt(OpPacket, 32'd5);             // duplicate of newest
        send_pkt(OpPacket, 32'd36);            // shift by one less than the window
        send_pkt(OpPacket, 32'd0);             // too old, ignored
        send_pkt(OpDecay, 32'hFFFF_FFFF);      // interval passed, halves
        send_pkt(OpDecay, 32'd0);              // no advance, no effect
        send_pkt(OpPacket, 32'd68);            // jump of exactly the window size
        send_pkt(OpPacket, 32'd101);           // jump just over the window
        send_pkt(OpPacket, 32'd164);           // jump just under twice the window
        send_pkt(OpPacket, 32'd228);           // jump of exactly twice the window
        send_pkt(OpPacket, 32'hFFFF_FFFF);     // largest id, huge gap
        send_pkt(OpPacket, 32'hFFFF_FFFE);
        send_pkt(OpWinReset, 32'h5555_5555);   // window only, counters kept
        send_pkt(OpPacket, 32'd10);            // new id below window size clears counts
        send_pkt(OpPacket, 32'd40);
        send_pkt(OpPacket, 32'hAAAA_AAAA);
        send_pkt(OpFullReset, 32'hFFFF_FFFF);
        send_pkt(OpPacket, 32'd31);            // largest id still below window size
        send_pkt(OpPacket, 32'h8000_0000);
        send_pkt(OpDecay, 32'd0);
        send_pkt(OpPacket, 32'h7FFF_FFFF);     // one behind newest, fills bit 1
        send_pkt(OpDecay, 32'h1234_5678);
        end_burst();
    endtask

    // mostly an orderly stream with some reordering, with jumps, decays
    // and the occasional reset mixed in
    task automatic run_random(input int count);
        int          pick;
        logic [31:0] id;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 58)
                send_pkt(OpPacket, sb.newest + 32'($urandom_range(1, 4)));
            else if (pick < 76)
                send_pkt(OpPacket, sb.newest - 32'($urandom_range(0, 40)));
            else if (pick < 83)
                send_pkt(OpPacket, sb.newest + 32'($urandom_range(5, 70)));
            else if (pick < 85)
                send_pkt(OpPacket, $urandom());
            else if (pick < 94)
                send_pkt(OpDecay, $urandom());
            else if (pick < 97)
                send_pkt(OpWinReset, $urandom());
            else if (pick < 98)
                send_pkt(OpFullReset, $urandom());
            else
            begin
                id = 32'($urandom_range(0, 40));
                send_pkt(OpPacket, id);
            end
        end
        end_burst();
    endtask

    task automatic run_phase(input logic [IntvW-1:0] intv, input int idle_pct,
                             input int stall_pct);
        wait_drained();
        write_interval(intv);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        run_random(PhaseItems);
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        interval_writes = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // source side quiet from time zero, ready comes from the falling-edge driver
        rst_n <= 1'b0;
        pkt.valid <= 1'b0;
        pkt.opcode <= OpPacket;
        pkt.seq_id <= '0;
        cfg.valid <= 1'b0;
        cfg.data <= '0;

        // single reset, released at a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        // interval settings: one, maximum, zero, something mid-range, then the reset value
        run_phase(16'd1, 0, 0);
        run_phase(16'd65535, 63, 0);
        run_phase(16'd0, 0, 63);
        run_phase(16'($urandom_range(2, 64)), 22, 22);
        run_phase(16'd32, 0, 0);

        wait_drained();
        // let the pipeline settle and catch any stray result
        repeat (8) @(negedge clk);

        $display("run covered %0d packet/command transactions over %0d interval settings",
                 sb.inputs_noted, interval_writes + 1);
        $display("%0d stats results compared, %0d decays took effect, %0d failures",
                 sb.results_checked, sb.decays_applied, sb.failures);
        if (sb.failures == 0 && sb.pending_count() == 0)
            $display("PASS sliding_window_loss_counter");
        else
            $display("FAIL sliding_window_loss_counter");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/swlc_pkg.sv
sv/swlc_if.sv
sv/swlc_front.sv
sv/swlc_queue.sv
sv/swlc_back.sv
sv/sliding_window_loss_counter.sv
test/swlc_scoreboard_pkg.sv
test/sliding_window_loss_counter_test.sv
